>>> hw/rtl/knn_pkg.sv
// ----------------------------------------------------------------------------
// knn_pkg
// Shared constants and types for the weighted k-nearest-neighbor classifier.
// ----------------------------------------------------------------------------
package knn_pkg;

   localparam int NumSamples  = 1024;
   localparam int NumFeatures = 66;
   localparam int KNeighbours = 5;
   localparam int NumClasses  = 10;

   localparam int SampleW = 10;
   localparam int FeatW   = 7;
   localparam int ValueW  = 16;
   localparam int ClassW  = 4;
   localparam int DistW   = 23;
   localparam int CountW  = 11;
   localparam int AddrW   = 17;
   localparam int KIdxW   = 3;
   localparam int WeightW = 64;

   localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
   localparam logic [FeatW-1:0] LastFeat = FeatW'(NumFeatures - 1);

   localparam logic CmdLoad  = 1'b0;
   localparam logic CmdQuery = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_INSERT,
      ST_WEIGHT,
      ST_DIVIDE,
      ST_ACCUM,
      ST_PICK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [DistW-1:0] distance;
      logic [ClassW-1:0] cls;
   } cand_type;

endpackage

>>> hw/rtl/knn_divider.sv
// ----------------------------------------------------------------------------
// knn_divider
// Restoring divider: computes floor(2^60 / d^2), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module knn_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [knn_pkg::DistW-1:0]     distance,
   output logic                          done,
   output logic [knn_pkg::WeightW-1:0]   quotient
);
   import knn_pkg::*;

   localparam int DenW = 2 * DistW;

   logic [DenW-1:0]    den_ff, den_in;
   logic [DenW:0]      rem_ff, rem_in;
   logic [WeightW-1:0] quo_ff, quo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DenW:0]      shifted;
   logic [DenW:0]      diff;

   always_comb begin
      shifted = {rem_ff[DenW-1:0], (cnt_ff == 6'd60)};
      diff    = shifted - {1'b0, den_ff};
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         den_in  = DenW'(distance) * DenW'(distance);
         rem_in  = '0;
         quo_in  = '0;
         cnt_in  = 6'd60;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DenW]) begin
            rem_in = diff;
            quo_in = {quo_ff[WeightW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[WeightW-2:0], 1'b0};
         end
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/knn_store.sv
// ----------------------------------------------------------------------------
// knn_store
// Training feature, class and query memories with registered reads.
// ----------------------------------------------------------------------------
module knn_store (
   input  logic                         clock,
   input  logic                         feat_we,
   input  logic [knn_pkg::AddrW-1:0]    feat_waddr,
   input  logic [knn_pkg::ValueW-1:0]   feat_wdata,
   input  logic [knn_pkg::AddrW-1:0]    feat_raddr,
   output logic [knn_pkg::ValueW-1:0]   feat_rdata,
   input  logic                         cls_we,
   input  logic [knn_pkg::SampleW-1:0]  cls_waddr,
   input  logic [knn_pkg::ClassW-1:0]   cls_wdata,
   input  logic [knn_pkg::SampleW-1:0]  cls_raddr,
   output logic [knn_pkg::ClassW-1:0]   cls_rdata,
   input  logic                         qry_we,
   input  logic [knn_pkg::FeatW-1:0]    qry_waddr,
   input  logic [knn_pkg::ValueW-1:0]   qry_wdata,
   input  logic [knn_pkg::FeatW-1:0]    qry_raddr,
   output logic [knn_pkg::ValueW-1:0]   qry_rdata
);
   import knn_pkg::*;

   logic [ValueW-1:0] feat_mem [NumSamples*NumFeatures];
   logic [ClassW-1:0] cls_mem  [NumSamples];
   logic [ValueW-1:0] qry_mem  [NumFeatures];

   always_ff @(posedge clock) begin
      if (feat_we) begin
         feat_mem[feat_waddr] <= feat_wdata;
      end
      feat_rdata <= feat_mem[feat_raddr];
   end

   always_ff @(posedge clock) begin
      if (cls_we) begin
         cls_mem[cls_waddr] <= cls_wdata;
      end
      cls_rdata <= cls_mem[cls_raddr];
   end

   always_ff @(posedge clock) begin
      if (qry_we) begin
         qry_mem[qry_waddr] <= qry_wdata;
      end
      qry_rdata <= qry_mem[qry_raddr];
   end

endmodule

>>> hw/rtl/knn_weighted_vote_classifier_top.sv
// ----------------------------------------------------------------------------
// knn_weighted_vote_classifier_top
// Weighted k-nearest-neighbor classifier with L1 distance over stored vectors.
// ----------------------------------------------------------------------------
// Loads leave busy low, so another load can follow in the next cycle.
// A final query element starts the scan: for each sample in use, feature memory reads
// and accumulation of absolute differences, then an insert into the neighbor list.
// Nonzero-distance weights then come from the bit-serial divider; the vote follows.
// The result strobe is registered from ST_DONE, lasts one cycle and cannot be stalled.
// Synchronous reset clears control state and sets samples_in_use to 1024.
module knn_weighted_vote_classifier_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [knn_pkg::SampleW-1:0]   req_sample_index,
   input  logic [knn_pkg::FeatW-1:0]     req_feature_index,
   input  logic [knn_pkg::ValueW-1:0]    req_feature_value,
   input  logic [knn_pkg::ClassW-1:0]    req_class_label,
   input  logic                          csr_write,
   input  logic [knn_pkg::CountW-1:0]    csr_samples_in_use,
   output logic                          rsp_valid,
   output logic [knn_pkg::ClassW-1:0]    rsp_predicted_class,
   output logic [knn_pkg::DistW-1:0]     rsp_nearest_distance
);
   import knn_pkg::*;

   state_type state_ff, state_in;

   logic [CountW-1:0]  siu_ff;
   logic [CountW-1:0]  n_limit;
   logic [SampleW-1:0] samp_ff, samp_in;
   logic [FeatW-1:0]   fidx_ff, fidx_in;
   logic [AddrW-1:0]   base_ff, base_in;
   logic               rd_vld_ff;
   logic               last_rd_ff;
   logic [DistW+1:0]   sum_ff, sum_in;
   logic [DistW-1:0]   bd_ff [KNeighbours];
   logic [ClassW-1:0]  bc_ff [KNeighbours];
   logic [KNeighbours-1:0] bv_ff;
   logic [KIdxW-1:0]   k_ff, k_in;
   logic [ClassW-1:0]  pick_ff, pick_in;
   logic [WeightW-1:0] tot_ff [NumClasses];
   logic [WeightW-1:0] top_ff;
   logic [ClassW-1:0]  win_ff;
   logic               rsp_valid_ff;
   logic [ClassW-1:0]  rsp_cls_ff;
   logic [DistW-1:0]   rsp_dist_ff;

   logic accept, is_load, is_query;
   logic [ValueW-1:0] feat_rdata, qry_rdata;
   logic [ClassW-1:0] cls_rdata;
   logic [ValueW-1:0] absd;
   logic [DistW-1:0]  dist_sat;
   logic              div_start, div_done;
   logic [WeightW-1:0] quotient, weight, tsum;
   logic [DistW-1:0]  cur_dist;
   logic [ClassW-1:0] cur_cls;
   logic [AddrW-1:0]  rd_addr, wr_addr;
   logic [FeatW-1:0]  qry_raddr;
   logic [KNeighbours-1:0] ins_move, ins_here;

   assign accept   = start && !busy;
   assign is_load  = accept && (req_command == CmdLoad);
   assign is_query = accept && (req_command == CmdQuery) &&
                     (req_feature_index < FeatW'(NumFeatures));
   assign busy     = (state_ff != ST_IDLE);
   assign n_limit  = (siu_ff == '0) ? CountW'(1) :
                     (siu_ff > CountW'(NumSamples)) ? CountW'(NumSamples) : siu_ff;

   assign wr_addr   = AddrW'(req_sample_index) * AddrW'(NumFeatures)
                      + AddrW'(req_feature_index);
   assign rd_addr   = base_ff + AddrW'(fidx_ff);
   assign qry_raddr = fidx_ff;

   knn_store u_store (
      .clock      (clock),
      .feat_we    (is_load && (req_feature_index < FeatW'(NumFeatures))),
      .feat_waddr (wr_addr),
      .feat_wdata (req_feature_value),
      .feat_raddr (rd_addr),
      .feat_rdata (feat_rdata),
      .cls_we     (is_load),
      .cls_waddr  (req_sample_index),
      .cls_wdata  (req_class_label),
      .cls_raddr  (samp_ff),
      .cls_rdata  (cls_rdata),
      .qry_we     (is_query),
      .qry_waddr  (req_feature_index),
      .qry_wdata  (req_feature_value),
      .qry_raddr  (qry_raddr),
      .qry_rdata  (qry_rdata)
   );

   assign absd     = (feat_rdata > qry_rdata) ? feat_rdata - qry_rdata
                                              : qry_rdata - feat_rdata;
   assign dist_sat = (sum_ff > (DistW+2)'(DistMax)) ? DistMax : sum_ff[DistW-1:0];
   assign cur_dist = bd_ff[k_ff];
   assign cur_cls  = bc_ff[k_ff];

   always_comb begin
      for (int j = 0; j < KNeighbours; j++) begin
         ins_move[j] = !bv_ff[j] || (dist_sat < bd_ff[j]);
      end
      ins_here[0] = ins_move[0];
      for (int j = 1; j < KNeighbours; j++) begin
         ins_here[j] = ins_move[j] && bv_ff[j-1] && !(dist_sat < bd_ff[j-1]);
      end
   end

   assign div_start = (state_ff == ST_WEIGHT) && (k_ff != KIdxW'(KNeighbours)) &&
                      bv_ff[k_ff] && (cur_cls < ClassW'(NumClasses)) && (cur_dist != '0);

   knn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .distance (cur_dist),
      .done     (div_done),
      .quotient (quotient)
   );

   assign weight = (cur_dist == '0) ? (WeightW'(1) << 60) : quotient;
   assign tsum   = (tot_ff[cur_cls] > ~weight) ? {WeightW{1'b1}}
                                               : tot_ff[cur_cls] + weight;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_query && (req_feature_index == LastFeat)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (rd_vld_ff && last_rd_ff) begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            if (CountW'(samp_ff) + CountW'(1) >= n_limit) begin
               state_in = ST_WEIGHT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_WEIGHT: begin
            if (k_ff == KIdxW'(KNeighbours)) begin
               state_in = ST_PICK;
            end else if (div_start) begin
               state_in = ST_DIVIDE;
            end else if (bv_ff[k_ff] && (cur_cls < ClassW'(NumClasses))) begin
               state_in = ST_ACCUM;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: state_in = ST_WEIGHT;
         ST_PICK: begin
            if (pick_ff == ClassW'(NumClasses - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      samp_in = samp_ff;
      fidx_in = fidx_ff;
      base_in = base_ff;
      sum_in  = sum_ff;
      k_in    = k_ff;
      pick_in = pick_ff;
      unique case (state_ff)
         ST_IDLE: begin
            samp_in = '0;
            fidx_in = '0;
            base_in = '0;
            sum_in  = '0;
            k_in    = '0;
            pick_in = '0;
         end
         ST_SCAN: begin
            if (fidx_ff != LastFeat || !rd_vld_ff) begin
               if (fidx_ff != LastFeat) begin
                  fidx_in = fidx_ff + FeatW'(1);
               end
            end
            if (rd_vld_ff) begin
               sum_in = sum_ff + (DistW+2)'(absd);
            end
         end
         ST_INSERT: begin
            samp_in = samp_ff + SampleW'(1);
            base_in = base_ff + AddrW'(NumFeatures);
            fidx_in = '0;
            sum_in  = '0;
         end
         ST_WEIGHT: begin
            if (k_ff != KIdxW'(KNeighbours) &&
                !(bv_ff[k_ff] && (cur_cls < ClassW'(NumClasses)))) begin
               k_in = k_ff + KIdxW'(1);
            end else if (k_ff == KIdxW'(KNeighbours)) begin
               k_in = '0;
            end
         end
         ST_ACCUM: k_in = k_ff + KIdxW'(1);
         ST_PICK:  pick_in = pick_ff + ClassW'(1);
         default: ;
      endcase
   end

   // Read pipeline: one feature read issued per scan cycle, its data in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         siu_ff     <= CountW'(NumSamples);
         rd_vld_ff  <= 1'b0;
         last_rd_ff <= 1'b0;
         bv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            siu_ff <= csr_samples_in_use;
         end
         rd_vld_ff  <= (state_ff == ST_SCAN) && !(rd_vld_ff && last_rd_ff);
         last_rd_ff <= (state_ff == ST_SCAN) && (fidx_ff == LastFeat);
         rsp_valid_ff <= (state_ff == ST_DONE);
         if (state_ff == ST_IDLE && state_in == ST_SCAN) begin
            bv_ff <= '0;
         end else if (state_ff == ST_INSERT) begin
            if (ins_move[0]) begin
               bv_ff[0] <= 1'b1;
            end
            for (int j = 1; j < KNeighbours; j++) begin
               if (ins_move[j]) begin
                  bv_ff[j] <= ins_here[j] ? 1'b1 : bv_ff[j-1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      samp_ff <= samp_in;
      fidx_ff <= fidx_in;
      base_ff <= base_in;
      sum_ff  <= sum_in;
      k_ff    <= k_in;
      pick_ff <= pick_in;
      if (state_ff == ST_IDLE && state_in == ST_SCAN) begin
         for (int j = 0; j < KNeighbours; j++) begin
            bd_ff[j] <= DistMax;
            bc_ff[j] <= '0;
         end
         for (int c = 0; c < NumClasses; c++) begin
            tot_ff[c] <= '0;
         end
         top_ff <= '0;
         win_ff <= '0;
      end else if (state_ff == ST_INSERT) begin
         if (ins_move[0]) begin
            bd_ff[0] <= dist_sat;
            bc_ff[0] <= cls_rdata;
         end
         for (int j = 1; j < KNeighbours; j++) begin
            if (ins_move[j]) begin
               if (ins_here[j]) begin
                  bd_ff[j] <= dist_sat;
                  bc_ff[j] <= cls_rdata;
               end else begin
                  bd_ff[j] <= bd_ff[j-1];
                  bc_ff[j] <= bc_ff[j-1];
               end
            end
         end
      end else if (state_ff == ST_ACCUM) begin
         tot_ff[cur_cls] <= tsum;
      end else if (state_ff == ST_PICK) begin
         if (tot_ff[pick_ff] > top_ff) begin
            top_ff <= tot_ff[pick_ff];
            win_ff <= pick_ff;
         end
      end
      if (state_ff == ST_DONE) begin
         rsp_cls_ff  <= win_ff;
         rsp_dist_ff <= bd_ff[0];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predicted_class  = rsp_cls_ff;
   assign rsp_nearest_distance = rsp_dist_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !accept) else $error("transfer accepted while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_DONE) else $error("stray result");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_IDLE) else $error("result before idle");
`endif

endmodule

>>> test/knn_vote_checker.sv
// ----------------------------------------------------------------------------
// knn_vote_checker
// Watches the request, response and register ports of the classifier. It keeps
// its own copy of the training store, query vector and sample count, predicts
// the vote for every query transfer that ends a vector, and compares each
// response transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module knn_vote_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic                         req_command,
   input  logic [knn_pkg::SampleW-1:0]  req_sample_index,
   input  logic [knn_pkg::FeatW-1:0]    req_feature_index,
   input  logic [knn_pkg::ValueW-1:0]   req_feature_value,
   input  logic [knn_pkg::ClassW-1:0]   req_class_label,
   input  logic                         csr_write,
   input  logic [knn_pkg::CountW-1:0]   csr_samples_in_use,
   input  logic                         rsp_valid,
   input  logic [knn_pkg::ClassW-1:0]   rsp_predicted_class,
   input  logic [knn_pkg::DistW-1:0]    rsp_nearest_distance,
   output int                           mismatches,
   output int                           pending_votes,
   output int                           votes_checked,
   output int                           items_accepted
);
   timeunit 1ns;
   timeprecision 1ps;
   import knn_pkg::*;

   typedef struct {
      logic [ClassW-1:0] cls;
      logic [DistW-1:0]  distance;
   } vote_result_type;

   logic [ValueW-1:0] train_feat [NumSamples*NumFeatures];
   logic [ClassW-1:0] train_class [NumSamples];
   logic [ValueW-1:0] query_vec [NumFeatures];
   logic [CountW-1:0] samples_cfg;
   vote_result_type   vote_q [$];

   function automatic vote_result_type predict_vote();
      vote_result_type   res;
      logic [DistW-1:0]  bd [KNeighbours];
      logic [ClassW-1:0] bc [KNeighbours];
      longint unsigned   totals [NumClasses];
      longint unsigned   w;
      longint unsigned   top_total;
      int unsigned       n, sum, a, b, d;
      int                filled, pos, j, s, f, winner;
      n = samples_cfg;
      if (n == 0) n = 1;
      if (n > NumSamples) n = NumSamples;
      for (j = 0; j < KNeighbours; j++) begin
         bd[j] = DistMax;
         bc[j] = '0;
      end
      filled = 0;
      for (s = 0; s < n; s++) begin
         sum = 0;
         for (f = 0; f < NumFeatures; f++) begin
            a = train_feat[s*NumFeatures+f];
            b = query_vec[f];
            sum += (a > b) ? a - b : b - a;
         end
         d = (sum > DistMax) ? DistMax : sum;
         pos = filled;
         for (j = 0; j < filled; j++) begin
            if (d < bd[j]) begin
               pos = j;
               break;
            end
         end
         if (pos < KNeighbours) begin
            for (j = (filled < KNeighbours) ? filled : KNeighbours - 1; j > pos; j--) begin
               bd[j] = bd[j-1];
               bc[j] = bc[j-1];
            end
            bd[pos] = DistW'(d);
            bc[pos] = train_class[s];
            if (filled < KNeighbours) filled++;
         end
      end
      for (j = 0; j < NumClasses; j++) totals[j] = 0;
      for (j = 0; j < filled; j++) begin
         if (bc[j] < NumClasses) begin
            if (bd[j] == 0) w = 64'd1 << 60;
            else w = (64'd1 << 60) / (64'(bd[j]) * 64'(bd[j]));
            if (totals[bc[j]] > 64'hFFFF_FFFF_FFFF_FFFF - w)
               totals[bc[j]] = 64'hFFFF_FFFF_FFFF_FFFF;
            else
               totals[bc[j]] += w;
         end
      end
      top_total = 0;
      winner = 0;
      for (j = 0; j < NumClasses; j++) begin
         if (totals[j] > top_total) begin
            top_total = totals[j];
            winner = j;
         end
      end
      res.cls = ClassW'(winner);
      res.distance = bd[0];
      return res;
   endfunction

   always @(posedge clock) begin
      vote_result_type got, want;
      if (reset) begin
         for (int i = 0; i < NumSamples*NumFeatures; i++) train_feat[i] = '0;
         for (int i = 0; i < NumSamples; i++) train_class[i] = '0;
         for (int i = 0; i < NumFeatures; i++) query_vec[i] = '0;
         samples_cfg = CountW'(NumSamples);
         vote_q.delete();
         mismatches = 0;
         votes_checked = 0;
         items_accepted = 0;
      end else begin
         if (rsp_valid) begin
            got.cls = rsp_predicted_class;
            got.distance = rsp_nearest_distance;
            if (vote_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result class %0d distance %0d",
                           $realtime, got.cls, got.distance);
               mismatches++;
            end else begin
               want = vote_q.pop_front();
               votes_checked++;
               if (got.cls !== want.cls || got.distance !== want.distance) begin
                  if (mismatches < 10)
                     $display("%0t: result mismatch: class %0d/%0d distance %0d/%0d %s",
                              $realtime, got.cls, want.cls, got.distance, want.distance,
                              "(actual/expected)");
                  mismatches++;
               end
            end
         end
         if (csr_write) samples_cfg = csr_samples_in_use;
         if (start && !busy) begin
            items_accepted++;
            if (req_command == CmdLoad) begin
               train_class[req_sample_index] = req_class_label;
               if (req_feature_index < NumFeatures)
                  train_feat[req_sample_index*NumFeatures+req_feature_index] =
                     req_feature_value;
            end else if (req_feature_index < NumFeatures) begin
               query_vec[req_feature_index] = req_feature_value;
               if (req_feature_index == LastFeat) vote_q.push_back(predict_vote());
            end
         end
      end
      pending_votes = vote_q.size();
   end

endmodule

>>> test/tb_knn_weighted_vote_classifier_top.sv
// ----------------------------------------------------------------------------
// tb_knn_weighted_vote_classifier_top
// Drives load and query transfers into the classifier with random gaps, off in
// one phase, and several small sample counts around the neighbor count. The
// checker beside the block predicts and compares every vote.
// ----------------------------------------------------------------------------
module tb_knn_weighted_vote_classifier_top;
   timeunit 1ns;
   timeprecision 1ps;
   import knn_pkg::*;

   localparam int SmallSet = 6;
   localparam int StallLimit = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_command;
   logic [SampleW-1:0] req_sample_index;
   logic [FeatW-1:0]   req_feature_index;
   logic [ValueW-1:0]  req_feature_value;
   logic [ClassW-1:0]  req_class_label;
   logic               csr_write;
   logic [CountW-1:0]  csr_samples_in_use;
   logic               rsp_valid;
   logic [ClassW-1:0]  rsp_predicted_class;
   logic [DistW-1:0]   rsp_nearest_distance;
   int                 mismatches, pending_votes, votes_checked, items_accepted;
   int                 idle_cycles;
   bit                 gaps_on;

   knn_weighted_vote_classifier_top dut (
      .clock, .reset, .start, .busy,
      .req_command, .req_sample_index, .req_feature_index,
      .req_feature_value, .req_class_label,
      .csr_write, .csr_samples_in_use,
      .rsp_valid, .rsp_predicted_class, .rsp_nearest_distance
   );

   knn_vote_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("tb_knn_weighted_vote_classifier_top: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Feature patterns shared by loads and queries so that equal and zero
   // distances come up often.
   function automatic logic [ValueW-1:0] pattern_value(int f, int tmpl);
      if ($urandom_range(0, 9) == 0) return ValueW'($urandom);
      case (tmpl)
         0: return '0;
         1: return '1;
         default: return ValueW'(f * 1237 + tmpl * 4099);
      endcase
   endfunction

   task automatic put_item(logic cmd, int sample, int feat, logic [ValueW-1:0] value,
                           int cls);
      int gap;
      int r;
      gap = 0;
      if (gaps_on) begin
         r = $urandom_range(0, 99);
         if (r >= 90) gap = $urandom_range(10, 40);
         else if (r >= 60) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_command = cmd;
      req_sample_index = SampleW'(sample);
      req_feature_index = FeatW'(feat);
      req_feature_value = value;
      req_class_label = ClassW'(cls);
      do @(posedge clock); while (busy);
   endtask

   task automatic write_count(int count);
      @(negedge clock);
      start = 1'b0;
      wait (pending_votes == 0 && !busy);
      repeat (20) @(negedge clock);
      csr_write = 1'b1;
      csr_samples_in_use = CountW'(count);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic load_vector(int sample, int tmpl, int cls);
      for (int f = 0; f < NumFeatures; f++)
         put_item(CmdLoad, sample, f, pattern_value(f, tmpl), cls);
   endtask

   initial begin
      int r, tmpl;
      reset = 1'b1;
      start = 1'b0;
      req_command = CmdLoad;
      req_sample_index = '0;
      req_feature_index = '0;
      req_feature_value = '0;
      req_class_label = '0;
      csr_write = 1'b0;
      csr_samples_in_use = '0;
      gaps_on = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: a count of zero searches one sample, extremes of value,
      // ignored items and a label that casts no vote.
      write_count(0);
      for (int s = 0; s < SmallSet; s++)
         load_vector(s, $urandom_range(0, 3), $urandom_range(0, 15));
      for (int f = 0; f < NumFeatures; f++) put_item(CmdQuery, 0, f, '1, 0);
      put_item(CmdQuery, 0, 127, '0, 0);
      put_item(CmdQuery, 0, 66, '0, 0);
      put_item(CmdLoad, 0, 100, '1, 12);
      put_item(CmdQuery, 1023, LastFeat, '1, 0);
      put_item(CmdLoad, 0, 127, '0, 9);
      put_item(CmdLoad, 1023, 65, '1, 15);

      // Random part over several sample counts.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: write_count(1);
            1: write_count(KNeighbours);
            2: write_count(SmallSet);
            3: write_count(KNeighbours - 1);
            default: write_count($urandom_range(2, SmallSet));
         endcase
         gaps_on = (phase != 2);
         tmpl = $urandom_range(0, 3);
         for (int i = 0; i < 18; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35)
               put_item(CmdLoad, $urandom_range(0, SmallSet - 1), $urandom_range(0, 65),
                        pattern_value(0, $urandom_range(0, 3)), $urandom_range(0, 15));
            else if (r < 45)
               put_item(CmdLoad, $urandom_range(SmallSet, 1023), $urandom_range(0, 127),
                        ValueW'($urandom), $urandom_range(0, 15));
            else if (r < 50)
               put_item(CmdLoad, $urandom_range(0, SmallSet - 1), $urandom_range(66, 127),
                        ValueW'($urandom), $urandom_range(0, 15));
            else if (r < 70) begin
               r = $urandom_range(0, 64);
               put_item(CmdQuery, $urandom_range(0, 1023), r, pattern_value(r, tmpl),
                        $urandom_range(0, 15));
            end else if (r < 95)
               put_item(CmdQuery, $urandom_range(0, 1023), LastFeat,
                        pattern_value(65, tmpl), $urandom_range(0, 15));
            else
               put_item(CmdQuery, 0, $urandom_range(66, 127), ValueW'($urandom), 0);
         end
      end
      @(negedge clock);
      start = 1'b0;

      wait (pending_votes == 0);
      repeat (100) @(posedge clock);
      $display("Run covered %0d accepted transfers and %0d checked votes,",
               items_accepted, votes_checked);
      $display("with sample counts from one to %0d; %0d mismatches.",
               SmallSet, mismatches);
      if (mismatches == 0)
         $display("tb_knn_weighted_vote_classifier_top: clean");
      else
         $display("tb_knn_weighted_vote_classifier_top: errors");
      $finish;
   end

endmodule

>>> knn_weighted_vote_classifier_top.f
hw/rtl/knn_pkg.sv
hw/rtl/knn_divider.sv
hw/rtl/knn_store.sv
hw/rtl/knn_weighted_vote_classifier_top.sv
test/knn_vote_checker.sv
test/tb_knn_weighted_vote_classifier_top.sv
